FILE: rtl/core/cbts_pkg.sv
package cbts_pkg;

  localparam int CLK_W      = 19;
  localparam int RATE_W     = 10;
  localparam int DIV_W      = 15;
  localparam int PRESC_W    = 11;
  localparam int SEG1_W     = 5;
  localparam int SEG2_W     = 4;
  localparam int QUANTA_W   = 5;
  localparam int PAIR_COUNT = 18;
  localparam int IDX_W      = 5;
  localparam int STEP_CNT_W = 5;

  localparam logic [CLK_W-1:0]   CLK_RESET    = CLK_W'(42000);
  localparam logic [RATE_W-1:0]  RATE_MIN     = RATE_W'(10);
  localparam logic [RATE_W-1:0]  RATE_MAX     = RATE_W'(1000);
  localparam logic [CLK_W-1:0]   MAX_PRESCALE = CLK_W'(1024);
  localparam logic [IDX_W-1:0]   LAST_IDX     = IDX_W'(PAIR_COUNT - 1);
  localparam logic [STEP_CNT_W-1:0] DIV_STEPS = STEP_CNT_W'(CLK_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_RESULT
  } cbts_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } cbts_div_stat_t;

  // Segment pair table, tried in order.
  function automatic logic [SEG1_W-1:0] seg1_of(input logic [IDX_W-1:0] idx);
    logic [SEG1_W-1:0] s;
    case (idx)
      5'd0:    s = 5'd5;
      5'd1:    s = 5'd6;
      5'd2:    s = 5'd6;
      5'd3:    s = 5'd7;
      5'd4:    s = 5'd8;
      5'd5:    s = 5'd9;
      5'd6:    s = 5'd9;
      5'd7:    s = 5'd10;
      5'd8:    s = 5'd11;
      5'd9:    s = 5'd12;
      5'd10:   s = 5'd12;
      5'd11:   s = 5'd13;
      5'd12:   s = 5'd14;
      5'd13:   s = 5'd15;
      5'd14:   s = 5'd15;
      5'd15:   s = 5'd16;
      5'd16:   s = 5'd16;
      5'd17:   s = 5'd16;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [SEG2_W-1:0] seg2_of(input logic [IDX_W-1:0] idx);
    logic [SEG2_W-1:0] s;
    case (idx)
      5'd0, 5'd1:                   s = 4'd2;
      5'd2, 5'd3, 5'd4, 5'd5:       s = 4'd3;
      5'd6, 5'd7, 5'd8, 5'd9:       s = 4'd4;
      5'd10, 5'd11, 5'd12, 5'd13:   s = 4'd5;
      5'd14, 5'd15:                 s = 4'd6;
      5'd16:                        s = 4'd7;
      5'd17:                        s = 4'd8;
      default:                      s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [QUANTA_W-1:0] quanta_of(input logic [IDX_W-1:0] idx);
    return QUANTA_W'(1) + seg1_of(idx) + QUANTA_W'(seg2_of(idx));
  endfunction

endpackage

FILE: rtl/core/cbts_divider.sv
module cbts_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cbts_pkg::CLK_W-1:0]    dividend,
  input  logic [cbts_pkg::DIV_W-1:0]    divisor,
  output logic [cbts_pkg::CLK_W-1:0]    quotient,
  output cbts_pkg::cbts_div_stat_t      stat
);
  import cbts_pkg::*;

  // Restoring division, one quotient bit per cycle. The shift register
  // feeds dividend bits out at the top and takes quotient bits in at the bottom.
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [CLK_W-1:0]      shr_r, shr_nxt;
  logic                  done_r;
  logic [DIV_W:0]        trial;
  logic                  fits;

  assign trial = {rem_r, shr_r[CLK_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    shr_nxt = shr_r;
    if (start) begin
      cnt_nxt = DIV_STEPS;
      rem_nxt = '0;
      shr_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - STEP_CNT_W'(1);
      rem_nxt = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      shr_nxt = {shr_r[CLK_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= !start && (cnt_r == STEP_CNT_W'(1));
    end
    rem_r <= rem_nxt;
    shr_r <= shr_nxt;
  end

  assign quotient      = shr_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

FILE: rtl/core/can_bit_timing_search_core.sv
// CAN bit timing search.
// A requested bit rate in kbit/s enters on in_rate_kbps and is transferred
// at a rising edge where start is high and busy is low. The block then tries
// 18 fixed (seg1, seg2) pairs in order and reports the first one for which
// the peripheral clock divides exactly by rate times quanta with a quotient
// of 1 to 1024. The answer appears on the out_ ports for one cycle, marked
// by out_valid; the receiver cannot stall, so each result transfer is taken
// in that cycle. A rate outside 10..1000 or a failed search reports
// out_config_found low and all fields zero.
// For each pair the block forms the divisor, loads the bit-serial divider,
// runs 19 quotient steps, one per bit of the clock value, and then checks
// the remainder and the quotient. A hit ends the search; a rate out of
// range skips the search and goes straight to the result. One item is
// worked on at a time; busy stays high until the result cycle is over.
// cfg_wdata is written to the clock register (kHz) when cfg_we is high.
// Reset clears the control state and loads the clock register with 42000.
module can_bit_timing_search_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [cbts_pkg::RATE_W-1:0]     in_rate_kbps,
  output logic                            out_valid,
  output logic                            out_config_found,
  output logic [cbts_pkg::PRESC_W-1:0]    out_prescale_div,
  output logic [cbts_pkg::SEG1_W-1:0]     out_seg1_quanta,
  output logic [cbts_pkg::SEG2_W-1:0]     out_seg2_quanta,
  input  logic                            cfg_we,
  input  logic [cbts_pkg::CLK_W-1:0]      cfg_wdata
);
  import cbts_pkg::*;

  cbts_state_t          state_r, state_nxt;
  logic [CLK_W-1:0]     clk_khz_r;
  logic [RATE_W-1:0]    rate_r;
  logic [IDX_W-1:0]     idx_r;
  logic [DIV_W-1:0]     divisor_r;
  logic                 found_r;
  logic [PRESC_W-1:0]   presc_r;
  logic [SEG1_W-1:0]    seg1_r;
  logic [SEG2_W-1:0]    seg2_r;

  logic                 accept;
  logic                 rate_ok;
  logic                 div_start;
  logic [CLK_W-1:0]     quotient;
  cbts_div_stat_t       div_stat;
  logic                 hit;

  assign accept  = start && (state_r == ST_IDLE);
  assign rate_ok = (in_rate_kbps >= RATE_MIN) && (in_rate_kbps <= RATE_MAX);

  // A pair is taken when the division is exact and the prescaler is legal.
  assign hit = div_stat.rem_zero && (quotient != '0) && (quotient <= MAX_PRESCALE);

  cbts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clk_khz_r),
    .divisor  (divisor_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = rate_ok ? ST_MUL : ST_RESULT;
        end
      end
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_stat.done) begin
          if (hit || (idx_r == LAST_IDX)) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State-decoded outputs.
  always_comb begin
    busy      = 1'b1;
    div_start = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_START:  div_start = 1'b1;
      ST_RESULT: out_valid = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      clk_khz_r <= CLK_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        clk_khz_r <= cfg_wdata;
      end
    end
  end

  // Search datapath. The result registers start cleared for every item so
  // that a failed search reports zeros.
  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r  <= in_rate_kbps;
      idx_r   <= '0;
      found_r <= 1'b0;
      presc_r <= '0;
      seg1_r  <= '0;
      seg2_r  <= '0;
    end
    if (state_r == ST_MUL) begin
      divisor_r <= DIV_W'(rate_r) * DIV_W'(quanta_of(idx_r));
    end
    if ((state_r == ST_WAIT) && div_stat.done) begin
      if (hit) begin
        found_r <= 1'b1;
        presc_r <= quotient[PRESC_W-1:0];
        seg1_r  <= seg1_of(idx_r);
        seg2_r  <= seg2_of(idx_r);
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  assign out_config_found = found_r;
  assign out_prescale_div = presc_r;
  assign out_seg1_quanta  = seg1_r;
  assign out_seg2_quanta  = seg2_r;

endmodule
